// File: hw/rtl/jops_pkg.sv
// Shared types and constants for the JSON object pair scanner.
package jops_pkg;

  // Character codes
  localparam logic [7:0] CH_LBRACE = 8'h7B;  // {
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // }
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
  localparam logic [7:0] CH_RBRACK = 8'h5D;  // ]
  localparam logic [7:0] CH_COLON  = 8'h3A;  // :
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ,
  localparam logic [7:0] CH_QUOTE  = 8'h22;  // "
  localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Byte roles
  localparam logic [1:0] ROLE_STRUCT = 2'd0;
  localparam logic [1:0] ROLE_KEY    = 2'd1;
  localparam logic [1:0] ROLE_VALUE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_KEYESC = 2'd2;

  typedef enum logic [10:0] {
    PH_OPEN   = 11'b000_0000_0001,
    PH_MEMBER = 11'b000_0000_0010,
    PH_KEY    = 11'b000_0000_0100,
    PH_COLON  = 11'b000_0000_1000,
    PH_VALUE  = 11'b000_0001_0000,
    PH_VSTR   = 11'b000_0010_0000,
    PH_SCALAR = 11'b000_0100_0000,
    PH_NEST   = 11'b000_1000_0000,
    PH_NSTR   = 11'b001_0000_0000,
    PH_AFTER  = 11'b010_0000_0000,
    PH_TAIL   = 11'b100_0000_0000
  } phase_t;

  // Bracket stack command
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic kind;   // 1 square bracket, 0 brace
  } stack_cmd_t;

  // Result of one byte
  typedef struct packed {
    logic [1:0] role;
    logic       vdone;
    logic       mdone;
    logic [1:0] status;
  } scan_res_t;

endpackage

// File: hw/rtl/jops_stack.sv
// Bracket kind stack held as a shift register, top of stack at bit 0.
module jops_stack #(
  parameter int NEST_DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  jops_pkg::stack_cmd_t                  cmd,
  output logic [$clog2(NEST_DEPTH+1)-1:0]       level,
  output logic                                  top_kind,
  output logic                                  full
);

  localparam int LW = $clog2(NEST_DEPTH + 1);

  logic [NEST_DEPTH-1:0] kinds_r, kinds_nxt;
  logic [LW-1:0]         lvl_r, lvl_nxt;
  logic [NEST_DEPTH:0]   push_w, pop_w;

  always_comb begin
    push_w    = {kinds_r, cmd.kind};
    pop_w     = {1'b0, kinds_r} >> 1;
    kinds_nxt = kinds_r;
    lvl_nxt   = lvl_r;
    if (cmd.clear) begin
      lvl_nxt = '0;
    end else if (cmd.push) begin
      kinds_nxt = push_w[NEST_DEPTH-1:0];
      lvl_nxt   = lvl_r + LW'(1);
    end else if (cmd.pop) begin
      kinds_nxt = pop_w[NEST_DEPTH-1:0];
      lvl_nxt   = lvl_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    kinds_r <= kinds_nxt;
    if (!rst_n) begin
      lvl_r <= '0;
    end else begin
      lvl_r <= lvl_nxt;
    end
  end

  assign level    = lvl_r;
  assign top_kind = kinds_r[0];
  assign full     = (lvl_r == LW'(NEST_DEPTH));

  // level stays within the stack
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= LW'(NEST_DEPTH))
    else $error("stack level beyond depth");

  // no push onto a full stack
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && !cmd.clear) |-> !full)
    else $error("push on full stack");

endmodule

// File: hw/rtl/jops_scan.sv
// Scan state machine: classifies one byte and updates the scan state.
module jops_scan #(
  parameter int NEST_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           byte_in,
  input  logic                 last_byte,
  output jops_pkg::scan_res_t  res
);

  localparam int LW = $clog2(NEST_DEPTH + 1);

  jops_pkg::phase_t     phase_r, phase_nxt;
  logic                 esc_r, esc_nxt;
  logic [1:0]           err_r, err_nxt;
  jops_pkg::stack_cmd_t cmd;
  logic [LW-1:0]        level;
  logic                 top_kind;
  logic                 full;
  logic                 ws, is_open, is_close;
  logic [1:0]           role;
  logic                 vdone;
  logic [1:0]           status;

  jops_stack #(.NEST_DEPTH(NEST_DEPTH)) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .level    (level),
    .top_kind (top_kind),
    .full     (full)
  );

  always_comb begin
    ws = (byte_in == jops_pkg::CH_SPACE) || (byte_in == jops_pkg::CH_TAB) ||
         (byte_in == jops_pkg::CH_CR)    || (byte_in == jops_pkg::CH_LF);
    is_open  = (byte_in == jops_pkg::CH_LBRACE) || (byte_in == jops_pkg::CH_LBRACK);
    is_close = (byte_in == jops_pkg::CH_RBRACE) || (byte_in == jops_pkg::CH_RBRACK);
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    err_nxt   = err_r;
    role      = jops_pkg::ROLE_STRUCT;
    vdone     = 1'b0;
    cmd       = '0;
    cmd.kind  = (byte_in == jops_pkg::CH_LBRACK);

    if (err_r == jops_pkg::ST_OK) begin
      case (phase_r)
        jops_pkg::PH_OPEN: begin
          if (byte_in == jops_pkg::CH_LBRACE) phase_nxt = jops_pkg::PH_MEMBER;
          else if (!ws) err_nxt = jops_pkg::ST_BAD;
        end
        jops_pkg::PH_MEMBER: begin
          if (byte_in == jops_pkg::CH_RBRACE) phase_nxt = jops_pkg::PH_TAIL;
          else if (byte_in == jops_pkg::CH_QUOTE) phase_nxt = jops_pkg::PH_KEY;
          else if (!ws) err_nxt = jops_pkg::ST_BAD;
        end
        jops_pkg::PH_KEY: begin
          if (byte_in == jops_pkg::CH_BSLASH) err_nxt = jops_pkg::ST_KEYESC;
          else if (byte_in == jops_pkg::CH_QUOTE) phase_nxt = jops_pkg::PH_COLON;
          else role = jops_pkg::ROLE_KEY;
        end
        jops_pkg::PH_COLON: begin
          if (byte_in == jops_pkg::CH_COLON) phase_nxt = jops_pkg::PH_VALUE;
          else if (!ws) err_nxt = jops_pkg::ST_BAD;
        end
        jops_pkg::PH_VALUE: begin
          if (ws) begin
            phase_nxt = phase_r;
          end else if (byte_in == jops_pkg::CH_COMMA) begin
            vdone     = 1'b1;
            phase_nxt = jops_pkg::PH_MEMBER;
          end else if (byte_in == jops_pkg::CH_RBRACE) begin
            vdone     = 1'b1;
            phase_nxt = jops_pkg::PH_TAIL;
          end else if (byte_in == jops_pkg::CH_QUOTE) begin
            role      = jops_pkg::ROLE_VALUE;
            esc_nxt   = 1'b0;
            phase_nxt = jops_pkg::PH_VSTR;
          end else if (is_open) begin
            // stack is empty here, so this push makes level one
            role      = jops_pkg::ROLE_VALUE;
            cmd.push  = 1'b1;
            phase_nxt = jops_pkg::PH_NEST;
          end else begin
            role      = jops_pkg::ROLE_VALUE;
            phase_nxt = jops_pkg::PH_SCALAR;
          end
        end
        jops_pkg::PH_VSTR: begin
          role = jops_pkg::ROLE_VALUE;
          if (esc_r) esc_nxt = 1'b0;
          else if (byte_in == jops_pkg::CH_BSLASH) esc_nxt = 1'b1;
          else if (byte_in == jops_pkg::CH_QUOTE) begin
            vdone     = 1'b1;
            phase_nxt = jops_pkg::PH_AFTER;
          end
        end
        jops_pkg::PH_SCALAR: begin
          if (byte_in == jops_pkg::CH_COMMA) begin
            vdone     = 1'b1;
            phase_nxt = jops_pkg::PH_MEMBER;
          end else if (byte_in == jops_pkg::CH_RBRACE) begin
            vdone     = 1'b1;
            phase_nxt = jops_pkg::PH_TAIL;
          end else begin
            role = jops_pkg::ROLE_VALUE;
          end
        end
        jops_pkg::PH_NEST: begin
          if (byte_in == jops_pkg::CH_QUOTE) begin
            role      = jops_pkg::ROLE_VALUE;
            esc_nxt   = 1'b0;
            phase_nxt = jops_pkg::PH_NSTR;
          end else if (is_open) begin
            if (full) err_nxt = jops_pkg::ST_BAD;
            else begin
              role     = jops_pkg::ROLE_VALUE;
              cmd.push = 1'b1;
            end
          end else if (is_close) begin
            if (level == '0) err_nxt = jops_pkg::ST_BAD;
            else if ((byte_in == jops_pkg::CH_RBRACK) != top_kind) err_nxt = jops_pkg::ST_BAD;
            else begin
              role    = jops_pkg::ROLE_VALUE;
              cmd.pop = 1'b1;
              if (level == LW'(1)) begin
                vdone     = 1'b1;
                phase_nxt = jops_pkg::PH_AFTER;
              end
            end
          end else begin
            role = jops_pkg::ROLE_VALUE;
          end
        end
        jops_pkg::PH_NSTR: begin
          role = jops_pkg::ROLE_VALUE;
          if (esc_r) esc_nxt = 1'b0;
          else if (byte_in == jops_pkg::CH_BSLASH) esc_nxt = 1'b1;
          else if (byte_in == jops_pkg::CH_QUOTE) phase_nxt = jops_pkg::PH_NEST;
        end
        jops_pkg::PH_AFTER: begin
          if (byte_in == jops_pkg::CH_COMMA) phase_nxt = jops_pkg::PH_MEMBER;
          else if (byte_in == jops_pkg::CH_RBRACE) phase_nxt = jops_pkg::PH_TAIL;
          else if (!ws) err_nxt = jops_pkg::ST_BAD;
        end
        jops_pkg::PH_TAIL: begin
          if (!ws) err_nxt = jops_pkg::ST_BAD;
        end
        default: begin
          err_nxt = jops_pkg::ST_BAD;
        end
      endcase
    end

    // verdict on the final byte
    status = err_nxt;
    if (last_byte && (status == jops_pkg::ST_OK) && (phase_nxt != jops_pkg::PH_TAIL)) begin
      status = jops_pkg::ST_BAD;
    end

    cmd.push  = cmd.push & step;
    cmd.pop   = cmd.pop & step;
    cmd.clear = step & last_byte;

    res.role   = role;
    res.vdone  = vdone;
    res.mdone  = last_byte;
    res.status = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jops_pkg::PH_OPEN;
      esc_r   <= 1'b0;
      err_r   <= jops_pkg::ST_OK;
    end else if (step) begin
      if (last_byte) begin
        phase_r <= jops_pkg::PH_OPEN;
        esc_r   <= 1'b0;
        err_r   <= jops_pkg::ST_OK;
      end else begin
        phase_r <= phase_nxt;
        esc_r   <= esc_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // a latched error holds until the end of the message
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ((err_r != jops_pkg::ST_OK) && !(step && last_byte)) |=> (err_r == $past(err_r)))
    else $error("error latch changed mid message");

  // the final byte returns the scanner to its start
  a_msg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last_byte) |=> ((phase_r == jops_pkg::PH_OPEN) && (level == '0) && !esc_r))
    else $error("state not cleared after final byte");

  // open brackets only exist while inside a nested value
  a_nest_level: assert property (@(posedge clk) disable iff (!rst_n)
    ((err_r == jops_pkg::ST_OK) && (phase_r != jops_pkg::PH_NEST) &&
     (phase_r != jops_pkg::PH_NSTR)) |-> (level == '0))
    else $error("bracket level outside nested value");

endmodule

// File: hw/rtl/json_object_pair_scanner_top.sv
// Top level of the JSON object pair scanner: input register, scanner, result register.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, in_byte_in, in_last_byte   | word in
//  out     | out_valid, out_ready, out_byte_role,           | word out
//          | out_value_done, out_message_done, out_status   |
//
// One word per clock sustained while out_ready stays high. A word accepted into
// the input register is scanned there and then lands in the result register,
// from which its result is shown. The scan state loop (phase, escape, error
// latch and bracket stack) is closed by combinational logic around its registers.
// rst_n is synchronous and active low; it empties both registers and puts
// the scanner back to expecting an opening brace.
// A stall on out backs up through the result register into the input
// register; in_ready drops only when both hold a word.
module json_object_pair_scanner_top #(
  parameter int NEST_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_byte_role,
  output logic       out_value_done,
  output logic       out_message_done,
  output logic [1:0] out_status
);

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // result register
  logic                out_vld_r;
  jops_pkg::scan_res_t out_res_r;
  jops_pkg::scan_res_t res;

  logic adv;   // word moves from input register into result register

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  jops_scan #(.NEST_DEPTH(NEST_DEPTH)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .byte_in   (in_byte_r),
    .last_byte (in_last_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  // payload carries no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte_in;
      in_last_r <= in_last_byte;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_byte_role    = out_res_r.role;
  assign out_value_done   = out_res_r.vdone;
  assign out_message_done = out_res_r.mdone;
  assign out_status       = out_res_r.status;

  // a word held in the input register is never dropped while stalled
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> in_vld_r)
    else $error("input word lost during stall");

  // a scanned word always lands in the result register
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("result register missed a word");

endmodule
